// ----- hw/rtl/heightmap_triangle_height_query_defines.svh -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define HTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/htq_pkg.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: package
// Types, constants and helpers shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package htq_pkg;

	localparam int MAX_TILES_DEF = 256;
	localparam int FRONT_DEPTH   = 4;
	localparam int OUTQ_DEPTH    = 8;

	localparam logic       CMD_WRITE  = 1'b0;
	localparam logic       CMD_QUERY  = 1'b1;
	localparam logic [8:0] TILE_RESET = 9'd256;

	typedef struct packed {
		logic        is_query;
		logic        in_range;
		logic        upper;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  fx;
		logic [7:0]  fz;
		logic [16:0] wr_index;
		logic [7:0]  wr_height;
	} htq_op_t;

	typedef struct packed {
		logic [15:0] height;
		logic        in_range;
	} htq_res_t;

	function automatic logic [8:0] clamp_tiles(input logic [8:0] tc, input int max_tiles);
		return (32'(tc) > max_tiles) ? 9'(max_tiles) : tc;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/htq_ifs.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: channel interfaces
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface htq_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [16:0]        write_index;
	logic [7:0]         write_height;
	logic signed [16:0] query_x;
	logic signed [16:0] query_z;

	modport source (output valid, cmd, write_index, write_height, query_x, query_z,
		input ready);
	modport sink (input valid, cmd, write_index, write_height, query_x, query_z,
		output ready);
endinterface

interface htq_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] height;
	logic        in_range;

	modport source (output valid, height, in_range, input ready);
	modport sink (input valid, height, in_range, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/heightmap_triangle_height_query.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: top level
// Grid height store with triangle interpolation of fixed-point queries.
// ----------------------------------------------------------------------------
// The block takes one item, write or query, every clock cycle while its queues
// have room, and gives one result beat per query, in order; writes give none.
// A query result passes through the front queue, then four back-end stages
// (row times stride, base address, store read, corner products), then the
// result queue. The rate is set by the store, which is held as four identical
// copies so that all four cell corners are read in the same cycle. The store
// is not cleared by reset; a query must only touch vertices that were written.
// The tile count may be changed only while no item is in flight.
`default_nettype none

module heightmap_triangle_height_query #(
	parameter int MAX_TILES = htq_pkg::MAX_TILES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	htq_in_if.sink     item,
	htq_out_if.source  result,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	logic [8:0]       tiles_q;
	htq_pkg::htq_op_t op;
	logic             op_valid;
	logic             op_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_q <= htq_pkg::clamp_tiles(htq_pkg::TILE_RESET, MAX_TILES);
		end else if (cfg_we) begin
			tiles_q <= htq_pkg::clamp_tiles(cfg_wdata, MAX_TILES);
		end
	end

	htq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.tiles   (tiles_q),
		.item    (item),
		.op_pop  (op_pop),
		.op      (op),
		.op_valid(op_valid)
	);

	htq_back #(
		.MAX_TILES(MAX_TILES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tiles   (tiles_q),
		.op      (op),
		.op_valid(op_valid),
		.op_pop  (op_pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/htq_fifo.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: queue
// Small first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
`default_nettype none

module htq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/htq_store.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: height store copy
// One copy of the vertex height memory, one write port and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module htq_store #(
	parameter int DEPTH = 66049,
	parameter int AW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/htq_front.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: front end
// Accepts items, checks the query range, splits coordinates and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module htq_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [8:0]      tiles,
	htq_in_if.sink          item,
	input  logic            op_pop,
	output htq_pkg::htq_op_t op,
	output logic            op_valid
);

	htq_pkg::htq_op_t op_in;
	logic             q_full;
	logic             q_empty;
	logic [16:0]      lim;
	logic [8:0]       fsum;
	logic             x_ok;
	logic             z_ok;

	assign lim  = {tiles, 8'h00};
	assign x_ok = !item.query_x[16] && ({1'b0, item.query_x[15:0]} < lim);
	assign z_ok = !item.query_z[16] && ({1'b0, item.query_z[15:0]} < lim);
	assign fsum = {1'b0, item.query_x[7:0]} + {1'b0, item.query_z[7:0]};

	always_comb begin
		op_in           = '0;
		op_in.is_query  = (item.cmd == htq_pkg::CMD_QUERY);
		op_in.in_range  = x_ok && z_ok;
		op_in.upper     = fsum[8];
		op_in.col       = item.query_x[15:8];
		op_in.row       = item.query_z[15:8];
		op_in.fx        = item.query_x[7:0];
		op_in.fz        = item.query_z[7:0];
		op_in.wr_index  = item.write_index;
		op_in.wr_height = item.write_height;
	end

	assign item.ready = !q_full;
	assign op_valid   = !q_empty;

	htq_fifo #(
		.WIDTH($bits(htq_pkg::htq_op_t)),
		.DEPTH(htq_pkg::FRONT_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (item.valid && item.ready),
		.push_data(op_in),
		.pop      (op_pop),
		.pop_data (op),
		.full     (q_full),
		.empty    (q_empty)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/htq_back.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: back end
// Addresses the store, reads the cell corners, interpolates and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module htq_back #(
	parameter int MAX_TILES = htq_pkg::MAX_TILES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [8:0]       tiles,
	input  htq_pkg::htq_op_t op,
	input  logic             op_valid,
	output logic             op_pop,
	htq_out_if.source        result
);

	localparam int STORE_DEPTH = (MAX_TILES + 1) * (MAX_TILES + 1);
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int OCC_W       = $clog2(htq_pkg::OUTQ_DEPTH + 1);

	logic [9:0]  stride;
	logic [17:0] stride18;

	logic             v_s1, v_s2, v_s3, v_s4;
	htq_pkg::htq_op_t op_s1, op_s2, op_s3;
	logic [17:0]      prod_s1;
	logic [17:0]      base_s2;

	logic [AW-1:0] raddr [4];
	logic [7:0]    hgt [4];
	logic          we;

	logic              lower;
	logic [7:0]        corner;
	logic signed [8:0] d1, d2;
	logic [8:0]        w1, w2;
	logic signed [18:0] p1, p2;

	logic               is_query_s4;
	logic               in_range_s4;
	logic [15:0]        base_s4;
	logic signed [18:0] p1_s4, p2_s4;
	logic signed [18:0] sum;

	htq_pkg::htq_res_t res_in;
	htq_pkg::htq_res_t res_out;
	logic              oq_empty;
	logic              oq_full;
	logic              beat;
	logic              drop;
	logic [OCC_W-1:0]  occ_q;

	assign stride   = {1'b0, tiles} + 10'd1;
	assign stride18 = {8'b0, stride};
	assign op_pop   = op_valid && (occ_q < OCC_W'(htq_pkg::OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= op_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= op;
		prod_s1     <= 18'(op.row) * 18'(stride);
		op_s2       <= op_s1;
		base_s2     <= prod_s1 + {10'b0, op_s1.col};
		op_s3       <= op_s2;
		is_query_s4 <= op_s3.is_query;
		in_range_s4 <= op_s3.in_range;
		base_s4     <= {corner, 8'h00};
		p1_s4       <= p1;
		p2_s4       <= p2;
	end

	assign raddr[0] = AW'(base_s2);
	assign raddr[1] = AW'(base_s2 + stride18);
	assign raddr[2] = AW'(base_s2 + stride18 + 18'd1);
	assign raddr[3] = AW'(base_s2 + 18'd1);
	assign we       = v_s2 && !op_s2.is_query && (32'(op_s2.wr_index) < STORE_DEPTH);

	for (genvar i = 0; i < 4; i++) begin : g_copy
		htq_store #(
			.DEPTH(STORE_DEPTH),
			.AW   (AW)
		) u_store (
			.clk  (clk),
			.we   (we),
			.waddr(AW'(op_s2.wr_index)),
			.wdata(op_s2.wr_height),
			.raddr(raddr[i]),
			.rdata(hgt[i])
		);
	end

	always_comb begin
		lower  = !op_s3.upper;
		corner = lower ? hgt[0] : hgt[2];
		d1     = $signed({1'b0, hgt[1]}) - $signed({1'b0, corner});
		d2     = $signed({1'b0, hgt[3]}) - $signed({1'b0, corner});
		w1     = lower ? {1'b0, op_s3.fz} : 9'd256 - {1'b0, op_s3.fx};
		w2     = lower ? {1'b0, op_s3.fx} : 9'd256 - {1'b0, op_s3.fz};
		p1     = 19'(d1) * 19'($signed({1'b0, w1}));
		p2     = 19'(d2) * 19'($signed({1'b0, w2}));
	end

	assign sum = $signed({3'b0, base_s4}) + p1_s4 + p2_s4;

	always_comb begin
		res_in.in_range = in_range_s4;
		res_in.height   = in_range_s4 ? sum[15:0] : 16'h0000;
	end

	assign beat = result.valid && result.ready;
	assign drop = v_s4 && !is_query_s4;

	htq_fifo #(
		.WIDTH($bits(htq_pkg::htq_res_t)),
		.DEPTH(htq_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s4 && is_query_s4),
		.push_data(res_in),
		.pop      (beat),
		.pop_data (res_out),
		.full     (oq_full),
		.empty    (oq_empty)
	);

	assign result.valid    = !oq_empty;
	assign result.height   = res_out.height;
	assign result.in_range = res_out.in_range && !oq_full | res_out.in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(op_pop) - OCC_W'(beat) - OCC_W'(drop);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/htq_checker.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query: port checker
// Checks result beats as seen on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heightmap_triangle_height_query_defines.svh"

module htq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_height,
	input logic        res_in_range
);

	`HTQ_ASSERT_IMP(a_outside_zero, res_valid && !res_in_range, res_height == 16'h0000, "Outside query with nonzero height")
	`HTQ_ASSERT_IMP(a_height_bound, res_valid && res_in_range, res_height <= 16'hFF00, "Height above the largest corner value")
	`HTQ_ASSERT_NXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_height) && $stable(res_in_range), "Stalled result beat changed")

endmodule

bind heightmap_triangle_height_query htq_checker u_htq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_height  (result.height),
	.res_in_range(result.in_range)
);

`default_nettype wire

// ----- sim/heightmap_triangle_height_query_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap triangle height query: testbench
// Loads grid heights through write beats, then drives queries. Most queries
// fall in cells whose four corners were written just before, and some lie
// outside the grid. Checks every result beat against an in-order
// interpolation of the same grid, across several tile counts and with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query_tb;

	localparam int STORE_DEPTH   = (htq_pkg::MAX_TILES_DEF + 1) * (htq_pkg::MAX_TILES_DEF + 1);
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 120;

	class height_grid_tracker;
		logic [7:0]        heights [STORE_DEPTH];
		bit                written [STORE_DEPTH];
		int unsigned       tile_count;
		htq_pkg::htq_res_t awaited_heights[$];
		int                mismatches;
		int                results_seen;
		int                inside_seen;

		function new();
			tile_count = 32'(htq_pkg::TILE_RESET);
		endfunction

		function int active_tiles();
			return (tile_count > htq_pkg::MAX_TILES_DEF) ? htq_pkg::MAX_TILES_DEF : tile_count;
		endfunction

		function htq_pkg::htq_res_t interpolate_height(int x, int z);
			int tiles, lim, col, row, fx, fz, stride, base;
			int h0, h1, h2, h3, acc;
			htq_pkg::htq_res_t r;
			tiles = active_tiles();
			lim = tiles * 256;
			r.height = '0;
			r.in_range = 1'b0;
			if (x < 0 || z < 0 || x >= lim || z >= lim)
				return r;
			col = x >> 8;
			row = z >> 8;
			fx = x & 255;
			fz = z & 255;
			stride = tiles + 1;
			base = row * stride + col;
			h0 = int'(heights[base]);
			h1 = int'(heights[base + stride]);
			h2 = int'(heights[base + stride + 1]);
			h3 = int'(heights[base + 1]);
			if (fx + fz < 256)
				acc = h0 * 256 + (h1 - h0) * fz + (h3 - h0) * fx;
			else
				acc = h2 * 256 + (h1 - h2) * (256 - fx) + (h3 - h2) * (256 - fz);
			r.height = acc[15:0];
			r.in_range = 1'b1;
			return r;
		endfunction

		function void note_item(logic cmd, logic [16:0] idx, logic [7:0] h,
			logic signed [16:0] qx, logic signed [16:0] qz);
			htq_pkg::htq_res_t r;
			if (cmd == htq_pkg::CMD_WRITE) begin
				if (idx < STORE_DEPTH) begin
					heights[idx] = h;
					written[idx] = 1'b1;
				end
			end else begin
				r = interpolate_height(int'(qx), int'(qz));
				awaited_heights.insert(awaited_heights.size(), r);
			end
		endfunction

		function void check_result(logic [15:0] height, logic in_range);
			htq_pkg::htq_res_t e;
			if (awaited_heights.size() == 0) begin
				$error("result beat with no query waiting: height %0d in_range %0b",
					height, in_range);
				mismatches++;
				return;
			end
			e = awaited_heights.pop_front();
			results_seen++;
			if (height !== e.height) begin
				$error("height: expected %0d, actual %0d", e.height, height);
				mismatches++;
			end
			if (in_range !== e.in_range) begin
				$error("in_range: expected %0b, actual %0b", e.in_range, in_range);
				mismatches++;
			end
			if (e.in_range)
				inside_seen++;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	htq_in_if  item_ch ();
	htq_out_if res_ch ();

	height_grid_tracker grid = new();

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int writes_sent;
	int queries_sent;
	int tile_settings;

	heightmap_triangle_height_query uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$error("run did not finish in time");
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				grid.check_result(res_ch.height, res_ch.in_range);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				stall_left = $urandom_range(1, 7) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic cmd, input logic [16:0] idx, input logic [7:0] h,
		input logic signed [16:0] qx, input logic signed [16:0] qz);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.cmd          <= cmd;
		item_ch.write_index  <= idx;
		item_ch.write_height <= h;
		item_ch.query_x      <= qx;
		item_ch.query_z      <= qz;
		do @(posedge clk); while (!item_ch.ready);
		grid.note_item(cmd, idx, h, qx, qz);
		if (cmd == htq_pkg::CMD_QUERY) begin
			queries_sent++;
			items_sent++;
		end else begin
			writes_sent++;
			if (idx < STORE_DEPTH)
				items_sent++;
		end
	endtask

	task automatic send_write(input int idx, input int h);
		send_item(htq_pkg::CMD_WRITE, 17'(idx), 8'(h), 17'($urandom), 17'($urandom));
	endtask

	task automatic send_query(input int x, input int z);
		send_item(htq_pkg::CMD_QUERY, 17'($urandom), 8'($urandom), 17'(x), 17'(z));
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (grid.awaited_heights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tiles(input int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= 9'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		grid.tile_count = value;
		tile_settings++;
	endtask

	function automatic int pick_height();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int pick_coord(int t);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return t - 1;
			default: return $urandom_range(0, t - 1);
		endcase
	endfunction

	// Every corner that a query reads must hold a written height.
	task automatic prepare_cell(input int row, input int col);
		int stride, base;
		int corner[4];
		stride = grid.active_tiles() + 1;
		base = row * stride + col;
		corner = '{base, base + 1, base + stride, base + stride + 1};
		foreach (corner[k])
			if (!grid.written[corner[k]] || $urandom_range(0, 3) == 0)
				send_write(corner[k], pick_height());
	endtask

	task automatic query_cell(input int row, input int col);
		int fx, fz;
		fx = $urandom_range(0, 255);
		fz = $urandom_range(0, 255);
		case ($urandom_range(0, 4))
			0: fz = 255 - fx;
			1: begin
				fx = $urandom_range(1, 255);
				fz = 256 - fx;
			end
			2: begin
				fx = $urandom_range(0, 1) * 255;
				fz = $urandom_range(0, 1) * 255;
			end
			default: ;
		endcase
		send_query(col * 256 + fx, row * 256 + fz);
	endtask

	task automatic query_outside();
		int lim, x, z;
		lim = grid.active_tiles() * 256;
		x = int'($urandom_range(0, 131071)) - 65536;
		z = int'($urandom_range(0, 131071)) - 65536;
		case ($urandom_range(0, 3))
			0: x = -int'($urandom_range(1, 65536));
			1: z = -int'($urandom_range(1, 65536));
			2: x = (lim <= 65535) ? lim + int'($urandom_range(0, 65535 - lim)) : -1;
			default: z = (lim <= 65535) ? lim + int'($urandom_range(0, 65535 - lim)) : -1;
		endcase
		send_query(x, z);
	endtask

	task automatic query_anywhere();
		int lim, x, z;
		lim = grid.active_tiles() * 256;
		x = int'($urandom_range(0, 131071)) - 65536;
		z = int'($urandom_range(0, 131071)) - 65536;
		if (x >= 0 && z >= 0 && x < lim && z < lim)
			prepare_cell(z >> 8, x >> 8);
		send_query(x, z);
	endtask

	task automatic run_phase(input int n_items, input bit idle_on);
		int start, t, r, row, col;
		start = items_sent;
		send_idle_pct = idle_on ? 10 * $urandom_range(0, 5) : 0;
		recv_idle_pct = idle_on ? 10 * $urandom_range(0, 5) : 0;
		t = grid.active_tiles();
		while (items_sent - start < n_items) begin
			r = $urandom_range(0, 99);
			if (t == 0 && r < 75)
				r = 80;
			if (r < 65) begin
				row = pick_coord(t);
				col = pick_coord(t);
				prepare_cell(row, col);
				repeat ($urandom_range(1, 3)) query_cell(row, col);
			end else if (r < 75) begin
				query_anywhere();
			end else if (r < 88) begin
				query_outside();
			end else if (r < 94) begin
				send_write($urandom_range(0, STORE_DEPTH - 1), pick_height());
			end else begin
				send_write($urandom_range(0, 131071), pick_height());
			end
		end
	endtask

	initial begin
		int tile_plan[9];
		tile_plan = '{1, 2, 0, 17, 511, 300, 255, 3, 256};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = htq_pkg::CMD_WRITE;
		item_ch.write_index = '0;
		item_ch.write_height = '0;
		item_ch.query_x = '0;
		item_ch.query_z = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cells of the full grid at the reset tile count.
		send_idle_pct = 30;
		recv_idle_pct = 30;
		send_write(0, 0);
		send_write(1, 255);
		send_write(257, 255);
		send_write(258, 0);
		send_query(0, 0);
		send_query(255, 0);
		send_query(0, 255);
		send_query(127, 128);
		send_query(128, 128);
		send_query(255, 255);
		send_write(65790, 255);
		send_write(65791, 255);
		send_write(66047, 255);
		send_write(66048, 255);
		send_query(65535, 65535);
		send_query(-65536, 0);
		send_query(0, -1);
		send_query(65535, -65536);
		// Writes past the end of the store must leave the grid untouched.
		send_write(66049, 0);
		send_write(131071, 0);
		send_query(65535, 65535);
		send_query(128, 127);

		run_phase(PHASE_ITEMS, 1'b1);
		foreach (tile_plan[p]) begin
			set_tiles(tile_plan[p]);
			run_phase(PHASE_ITEMS, p != $size(tile_plan) - 1);
		end

		drain();
		$display("Checked %0d results, %0d inside the grid, from %0d queries and %0d writes.",
			grid.results_seen, grid.inside_seen, queries_sent, writes_sent);
		$display("Covered %0d tile counts after reset, including zero, one and clamped values.",
			tile_settings);
		if (grid.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
